// ----- sv/urlv_pkg.sv -----
package urlv_pkg;

    // Phases of the URL walk. The one unused code of the 3-bit field counts as a failure.
    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_SCHEME = 3'd1,
        PH_COLON  = 3'd2,
        PH_SLASH1 = 3'd3,
        PH_HOST   = 3'd4,
        PH_PATH   = 3'd5,
        PH_FAIL   = 3'd6
    } phase_t;

    // Character classes of one URL byte, passed from the classifier to the phase logic.
    typedef struct packed {
        logic is_alpha;
        logic is_scheme;
        logic is_host;
        logic is_path;
        logic is_slash;
        logic is_slash_or_q;
        logic is_origin_lead;
        logic is_colon;
        logic is_at;
    } char_class_t;

    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_FORM_FEED = 8'd12;
    localparam logic [7:0] CH_PATH_LO   = 8'h21;
    localparam logic [7:0] CH_PATH_HI   = 8'd126;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_QUESTION  = 8'h3F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_AT        = 8'h40;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_DOT       = 8'h2E;

endpackage

// ----- sv/urlv_class.sv -----
module urlv_class (
    input  logic [7:0]          url_byte,
    output urlv_pkg::char_class_t cls
);
    import urlv_pkg::*;

    logic alpha;
    logic digit;
    logic host_punct;

    always_comb
    begin
        alpha = (url_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]});
        digit = (url_byte inside {[8'h30:8'h39]});
        // Punctuation allowed in the host part: ! $ % & ' ( ) * + , - . : ; = @ [ ] _ ~
        host_punct = (url_byte inside {8'h21, [8'h24:8'h2E], 8'h3A, 8'h3B, 8'h3D,
                                       8'h40, 8'h5B, 8'h5D, 8'h5F, 8'h7E});

        cls.is_alpha       = alpha;
        cls.is_scheme      = alpha || digit || (url_byte inside {CH_PLUS, CH_MINUS, CH_DOT});
        cls.is_host        = alpha || digit || host_punct;
        cls.is_path        = (url_byte inside {CH_TAB, CH_FORM_FEED, [CH_PATH_LO:CH_PATH_HI]});
        cls.is_slash       = (url_byte == CH_SLASH);
        cls.is_slash_or_q  = (url_byte inside {CH_SLASH, CH_QUESTION});
        cls.is_origin_lead = (url_byte inside {CH_SLASH, CH_STAR});
        cls.is_colon       = (url_byte == CH_COLON);
        cls.is_at          = (url_byte == CH_AT);
    end

endmodule

// ----- sv/urlv_fsm.sv -----
module urlv_fsm (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  has_byte,
    input  logic                  last_item,
    input  logic                  connect_method,
    input  urlv_pkg::char_class_t cls,
    output logic                  url_valid
);
    import urlv_pkg::*;

    phase_t phase_reg;
    phase_t phase_next;
    logic   prev_at_reg;
    logic   prev_at_next;
    phase_t phase_byte;
    logic   prev_at_byte;

    // Phase and '@' tracking after the current byte, before the end-of-URL reset.
    always_comb
    begin
        phase_byte   = phase_reg;
        prev_at_byte = prev_at_reg;
        if (has_byte)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (cls.is_origin_lead)
                    begin
                        phase_byte = PH_PATH;
                    end
                    else if (connect_method)
                    begin
                        // The host part begins at the first byte; no '@' precedes it.
                        if (cls.is_slash_or_q)
                        begin
                            phase_byte   = PH_PATH;
                            prev_at_byte = 1'b0;
                        end
                        else if (!cls.is_host)
                        begin
                            phase_byte   = PH_FAIL;
                            prev_at_byte = 1'b0;
                        end
                        else
                        begin
                            phase_byte   = PH_HOST;
                            prev_at_byte = cls.is_at;
                        end
                    end
                    else if (cls.is_alpha)
                    begin
                        phase_byte = PH_SCHEME;
                    end
                    else
                    begin
                        phase_byte = PH_FAIL;
                    end
                end
                PH_SCHEME:
                begin
                    if (cls.is_colon)
                    begin
                        phase_byte = PH_COLON;
                    end
                    else if (!cls.is_scheme)
                    begin
                        phase_byte = PH_FAIL;
                    end
                end
                PH_COLON:
                begin
                    phase_byte = cls.is_slash ? PH_SLASH1 : PH_FAIL;
                end
                PH_SLASH1:
                begin
                    phase_byte = cls.is_slash ? PH_HOST : PH_FAIL;
                end
                PH_HOST:
                begin
                    if (cls.is_slash_or_q)
                    begin
                        phase_byte   = PH_PATH;
                        prev_at_byte = 1'b0;
                    end
                    else if (!cls.is_host || (cls.is_at && prev_at_reg))
                    begin
                        phase_byte   = PH_FAIL;
                        prev_at_byte = 1'b0;
                    end
                    else
                    begin
                        prev_at_byte = cls.is_at;
                    end
                end
                PH_PATH:
                begin
                    if (!cls.is_path)
                    begin
                        phase_byte = PH_FAIL;
                    end
                end
                default:
                begin
                    phase_byte = PH_FAIL;
                end
            endcase
        end
    end

    // Next state: a verdict returns everything to the start of a new URL.
    always_comb
    begin
        phase_next   = phase_reg;
        prev_at_next = prev_at_reg;
        if (step)
        begin
            if (last_item)
            begin
                phase_next   = PH_START;
                prev_at_next = 1'b0;
            end
            else
            begin
                phase_next   = phase_byte;
                prev_at_next = prev_at_byte;
            end
        end
    end

    // Output: the URL is good only if it ends inside the host part or the path.
    always_comb
    begin
        url_valid = (phase_byte == PH_HOST) || (phase_byte == PH_PATH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            prev_at_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            prev_at_reg <= prev_at_next;
        end
    end

    // A verdict always leaves the walker at the start of a fresh URL.
    a_reset_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        step && last_item |=> (phase_reg == PH_START) && !prev_at_reg)
        else $error("phase not back at start after a verdict");

    // The '@' flag only has meaning inside the host part.
    a_at_only_in_host: assert property (@(posedge clk) disable iff (!rst_n)
        prev_at_reg |-> (phase_reg == PH_HOST))
        else $error("previous-'@' flag set outside the host part");

    // A failed URL stays failed until its verdict.
    a_fail_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FAIL) && step && !last_item |=> (phase_reg == PH_FAIL))
        else $error("walker left the fail phase before the verdict");

endmodule

// ----- sv/http_request_url_validator.sv -----
// HTTP request-target URL validator.
//
// The URL enters on the s_axis channel, one request per byte. tdata carries the
// byte, tuser[0] says whether tdata holds a byte at all (low for an ignored request
// or an end marker that closes an empty or already-sent URL), tuser[1] flags a
// CONNECT method and is looked at on the first byte of a URL, and tlast marks the
// final request. Exactly one verdict leaves on the m_axis channel for each
// request with tlast set: tdata[0] is 1 when the whole URL passed, 0 otherwise.
//
// Each request is captured in an input register and walked through the
// character classifier and the phase logic from there. The verdict is written
// into the output register when its closing request leaves the input register,
// which waits while the output register is full, and m_axis_tvalid rises. A new
// request is accepted every cycle unless a closing request is held in this way.
//
// If the receiver holds m_axis_tready low, the verdict waits in the output
// register while byte requests keep flowing. Only a second closing request,
// which would need the output register, waits in the input register and then
// drops s_axis_tready until the pending verdict is taken.
//
// Reset clears both valid flags and returns the walker to the start of a URL.
module http_request_url_validator (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] url_byte
    input  logic [1:0] s_axis_tuser,   // [0] has_byte, [1] connect_method
    input  logic       s_axis_tlast,   // last_item

    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] url_valid, [7:1] zero
);
    import urlv_pkg::*;

    // Input register.
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [7:0]  s1_byte_reg;
    logic        s1_has_reg;
    logic        s1_last_reg;
    logic        s1_conn_reg;

    // Result register.
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        url_valid_reg;

    char_class_t cls;
    logic        verdict;
    logic        out_free;
    logic        s1_advance;
    logic        s_accept;

    // The output register is free when empty or being emptied this cycle.
    assign out_free   = !out_valid_reg || m_axis_tready;
    // Only a closing request needs room in the output register.
    assign s1_advance = s1_valid_reg && (!s1_last_reg || out_free);
    assign s_axis_tready = !s1_valid_reg || s1_advance;
    assign s_accept   = s_axis_tvalid && s_axis_tready;

    urlv_class u_class (
        .url_byte (s1_byte_reg),
        .cls      (cls)
    );

    urlv_fsm u_fsm (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (s1_advance),
        .has_byte       (s1_has_reg),
        .last_item      (s1_last_reg),
        .connect_method (s1_conn_reg),
        .cls            (cls),
        .url_valid      (verdict)
    );

    always_comb
    begin
        s1_valid_next = s_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);

        out_valid_next = out_valid_reg;
        if (s1_advance && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_byte_reg <= s_axis_tdata;
            s1_has_reg  <= s_axis_tuser[0];
            s1_conn_reg <= s_axis_tuser[1];
            s1_last_reg <= s_axis_tlast;
        end
        if (s1_advance && s1_last_reg)
        begin
            url_valid_reg <= verdict;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, url_valid_reg};

    // A verdict only appears after a closing request has left the input register.
    a_verdict_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s1_valid_reg && s1_last_reg))
        else $error("verdict raised without a closing request");

    // A closing request blocked by a pending verdict must hold off new input.
    a_block_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_last_reg && out_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while a closing request is stuck");

    // Byte requests never wait on the output side.
    a_bytes_flow: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_last_reg |-> s_axis_tready)
        else $error("byte request stalled by the output register");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import urlv_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 10;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] url_byte
    logic [1:0] s_axis_tuser;   // [0] has_byte, [1] connect_method
    logic       s_axis_tlast;   // last_item
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [0] url_valid, [7:1] zero

    http_request_url_validator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Predicted verdicts, oldest first.
    logic       verdict_q[$];

    // Shadow copy of the URL walker state.
    phase_t     walk_phase;
    logic       walk_connect;
    logic       walk_prev_at;

    // URL under construction, handed to send_url.
    logic [7:0] url_buf[$];

    int         src_idle_pct;
    int         sink_stall_pct;
    logic       hold_request;
    int         cycle_count;
    int         error_count;
    int         counted_items;
    int         urls_sent;
    int         verdicts_checked;
    int         verdicts_valid;
    int         stall_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && s_axis_tvalid && !s_axis_tready)
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Character classes, written out from the URL grammar.
    // ------------------------------------------------------------------
    function automatic logic is_letter(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_numeral(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_path_byte(logic [7:0] c);
        return c == CH_TAB || c == CH_FORM_FEED || (c >= CH_PATH_LO && c <= CH_PATH_HI);
    endfunction

    function automatic logic is_scheme_byte(logic [7:0] c);
        return is_letter(c) || is_numeral(c) || c == CH_PLUS || c == CH_MINUS || c == CH_DOT;
    endfunction

    function automatic logic is_host_byte(logic [7:0] c);
        if (is_letter(c) || is_numeral(c))
            return 1'b1;
        case (c)
            "!", "$", "%", "&", "'", "(", ")", "*", "+", ",", "-", ".", ":", ";",
            "=", "@", "[", "]", "_", "~":
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    // One byte of the host part. A slash or question mark opens the path, and
    // two at-signs in a row are rejected.
    task automatic walk_host(input logic [7:0] c);
        if (c == CH_SLASH || c == CH_QUESTION)
        begin
            walk_phase   = PH_PATH;
            walk_prev_at = 1'b0;
        end
        else if (!is_host_byte(c) || (c == CH_AT && walk_prev_at))
        begin
            walk_phase   = PH_FAIL;
            walk_prev_at = 1'b0;
        end
        else
            walk_prev_at = (c == CH_AT);
    endtask

    task automatic reset_walk();
        walk_phase   = PH_START;
        walk_connect = 1'b0;
        walk_prev_at = 1'b0;
    endtask

    // Advances the shadow walker by one accepted request and queues the
    // verdict when the request closes the URL.
    task automatic predict_request(input logic [7:0] c, input logic has, input logic last,
                                   input logic conn);
        if (has)
        begin
            case (walk_phase)
                PH_START:
                begin
                    walk_connect = conn;
                    if (c == CH_SLASH || c == CH_STAR)
                        walk_phase = PH_PATH;
                    else if (walk_connect)
                    begin
                        walk_phase = PH_HOST;
                        walk_host(c);
                    end
                    else if (is_letter(c))
                        walk_phase = PH_SCHEME;
                    else
                        walk_phase = PH_FAIL;
                end
                PH_SCHEME:
                begin
                    if (c == CH_COLON)
                        walk_phase = PH_COLON;
                    else if (!is_scheme_byte(c))
                        walk_phase = PH_FAIL;
                end
                PH_COLON:  walk_phase = (c == CH_SLASH) ? PH_SLASH1 : PH_FAIL;
                PH_SLASH1: walk_phase = (c == CH_SLASH) ? PH_HOST : PH_FAIL;
                PH_HOST:   walk_host(c);
                PH_PATH:
                begin
                    if (!is_path_byte(c))
                        walk_phase = PH_FAIL;
                end
                default:   walk_phase = PH_FAIL;
            endcase
        end
        if (last)
        begin
            verdict_q = {verdict_q, (walk_phase == PH_HOST || walk_phase == PH_PATH)};
            reset_walk();
        end
    endtask

    // Input monitor: every accepted request goes through the predictor.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predict_request(s_axis_tdata, s_axis_tuser[0], s_axis_tlast, s_axis_tuser[1]);
            counted_items++;
        end
    end

    // Output checker: each verdict is matched against the oldest prediction.
    always @(posedge clk)
    begin
        logic exp_valid;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t: unexpected verdict, expected none, got tdata %h",
                         $realtime, m_axis_tdata);
                error_count++;
            end
            else
            begin
                exp_valid = verdict_q.pop_front();
                verdicts_checked++;
                if (exp_valid)
                    verdicts_valid++;
                if (m_axis_tdata[0] !== exp_valid)
                begin
                    $display("%0t: url_valid mismatch, expected %0b, got %0b",
                             $realtime, exp_valid, m_axis_tdata[0]);
                    error_count++;
                end
                if (m_axis_tdata[7:1] !== 7'd0)
                begin
                    $display("%0t: tdata padding mismatch, expected %h, got %h",
                             $realtime, 7'd0, m_axis_tdata[7:1]);
                    error_count++;
                end
            end
        end
    end

    // Receiver. A long hold-off, when requested, is counted down here while
    // the sender keeps offering requests, so the block backs up into s_axis.
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && hold_left == 0)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sending side.
    // ------------------------------------------------------------------

    // Appends one byte to the URL under construction.
    task automatic put_byte(input logic [7:0] c);
        url_buf = {url_buf, c};
    endtask

    // Offers one request after a random gap and waits until it is taken.
    task automatic send_req(input logic [7:0] c, input logic has, input logic last,
                            input logic conn);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= {conn, has};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Sends url_buf as one URL. The CONNECT flag is only meaningful on the
    // first byte, so later bytes carry a random one. Ignored byte-less
    // requests may be slipped in, and the URL may be closed by an end marker.
    task automatic send_url(input logic conn, input logic marker_end, input int ignore_pct);
        int n;
        n = url_buf.size();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < ignore_pct)
                send_req(8'($urandom_range(255)), 1'b0, 1'b0, 1'($urandom_range(1)));
            send_req(url_buf[i], 1'b1, (i == n - 1) && !marker_end,
                     (i == 0) ? conn : logic'($urandom_range(1)));
        end
        if (n == 0 || marker_end)
            send_req(8'($urandom_range(255)), 1'b0, 1'b1,
                     (n == 0) ? conn : logic'($urandom_range(1)));
        urls_sent++;
    endtask

    task automatic send_text(input string s, input logic conn, input logic marker_end);
        url_buf.delete();
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
        send_url(conn, marker_end, 0);
    endtask

    // Lowers tvalid, then waits until every predicted verdict has arrived.
    task automatic wait_drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Random URL construction.
    // ------------------------------------------------------------------
    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(51);
        return (r < 26) ? 8'(8'h41 + r) : 8'(8'h61 + r - 26);
    endfunction

    function automatic logic [7:0] rand_scheme_byte();
        string marks;
        marks = "+-.";
        case ($urandom_range(3))
            0, 1:    return rand_letter();
            2:       return 8'(8'h30 + $urandom_range(9));
            default: return marks[$urandom_range(2)];
        endcase
    endfunction

    function automatic logic [7:0] rand_host_byte();
        string marks;
        marks = "!$%&'()*+,-.:;=@[]_~";
        case ($urandom_range(2))
            0:       return rand_letter();
            1:       return 8'(8'h30 + $urandom_range(9));
            default: return marks[$urandom_range(marks.len() - 1)];
        endcase
    endfunction

    function automatic logic [7:0] rand_path_byte();
        case ($urandom_range(9))
            0:       return CH_TAB;
            1:       return CH_FORM_FEED;
            default: return 8'($urandom_range(CH_PATH_LO, CH_PATH_HI));
        endcase
    endfunction

    task automatic add_host_and_path();
        repeat ($urandom_range(6))
            put_byte(rand_host_byte());
        if ($urandom_range(9) == 0)
        begin
            put_byte(CH_AT);
            put_byte(CH_AT);
        end
        if ($urandom_range(3) != 0)
        begin
            put_byte($urandom_range(1) ? CH_SLASH : CH_QUESTION);
            repeat ($urandom_range(8))
                put_byte(rand_path_byte());
        end
    endtask

    task automatic add_absolute();
        put_byte(rand_letter());
        repeat ($urandom_range(4))
            put_byte(rand_scheme_byte());
        put_byte(CH_COLON);
        put_byte(CH_SLASH);
        put_byte(CH_SLASH);
        add_host_and_path();
    endtask

    // Mostly well-formed URLs of every form, then damaged ones and raw noise.
    task automatic make_random_url(output logic conn);
        int kind;
        int pos;
        url_buf.delete();
        kind = $urandom_range(99);
        conn = 1'b0;
        if (kind < 30)
        begin
            add_absolute();
            conn = ($urandom_range(9) == 0);
        end
        else if (kind < 50)
        begin
            put_byte($urandom_range(1) ? CH_SLASH : CH_STAR);
            repeat ($urandom_range(8))
                put_byte(rand_path_byte());
            conn = 1'($urandom_range(1));
        end
        else if (kind < 65)
        begin
            conn = 1'b1;
            add_host_and_path();
        end
        else if (kind < 85)
        begin
            add_absolute();
            pos = $urandom_range(url_buf.size() - 1);
            if ($urandom_range(1))
                url_buf[pos] = 8'($urandom_range(255));
            else
                while (url_buf.size() > pos)
                    void'(url_buf.pop_back());
        end
        else
        begin
            repeat ($urandom_range(6))
                put_byte(8'($urandom_range(255)));
            conn = 1'($urandom_range(1));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Empty URL, and byte-less requests both ignored and closing a URL.
    task automatic test_empty_and_markers();
        send_text("", 1'b0, 1'b0);
        url_buf.delete();
        put_byte("x");
        send_url(1'b1, 1'b1, 100);
        wait_drain();
    endtask

    // Origin, asterisk, absolute and CONNECT forms that should all pass.
    task automatic test_accepted_forms();
        send_text("/", 1'b0, 1'b0);
        url_buf.delete();
        put_byte(CH_STAR);
        put_byte(CH_TAB);
        put_byte(CH_FORM_FEED);
        put_byte(CH_PATH_HI);
        send_url(1'b0, 1'b0, 0);
        send_text("a://", 1'b0, 1'b0);
        send_text("h@x", 1'b1, 1'b0);
        wait_drain();
    endtask

    // A high byte, a zero byte, an unfinished scheme separator, a doubled
    // at-sign, and a failure that must persist up to the verdict.
    task automatic test_rejected_forms();
        url_buf.delete();
        put_byte(CH_STAR);
        put_byte(8'hFF);
        send_url(1'b0, 1'b0, 0);
        url_buf.delete();
        put_byte(8'h00);
        send_url(1'b0, 1'b0, 0);
        send_text("a:/", 1'b0, 1'b0);
        send_text("@@", 1'b1, 1'b0);
        send_text("1/", 1'b0, 1'b0);
        wait_drain();
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_items);
        int target;
        logic conn;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        target         = counted_items + n_items;
        while (counted_items < target)
        begin
            make_random_url(conn);
            send_url(conn, $urandom_range(99) < 15, 10);
        end
        wait_drain();
    endtask

    // The receiver holds off while single-byte URLs keep arriving, so the
    // verdict register and then the input register fill and s_axis stalls.
    task automatic test_output_hold_off();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_request   = 1'b1;
        repeat (40)
            send_text($urandom_range(1) ? "/" : "q", 1'b0, 1'b0);
        wait_drain();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = 8'd0;
        s_axis_tuser     = 2'd0;
        s_axis_tlast     = 1'b0;
        src_idle_pct     = 0;
        sink_stall_pct   = 0;
        hold_request     = 1'b0;
        cycle_count      = 0;
        error_count      = 0;
        counted_items    = 0;
        urls_sent        = 0;
        verdicts_checked = 0;
        verdicts_valid   = 0;
        stall_cycles     = 0;
        reset_walk();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_and_markers();
        test_accepted_forms();
        test_rejected_forms();
        test_random_traffic(0, 0, 360);
        test_random_traffic(79, 0, 360);
        test_random_traffic(0, 79, 360);
        test_random_traffic(24, 24, 360);
        test_output_hold_off();

        $display("Sent %0d URLs in %0d requests; %0d verdicts checked, %0d valid.",
                 urls_sent, counted_items, verdicts_checked, verdicts_valid);
        $display("Input was held off for %0d cycles across idle, stall and hold-off phases.",
                 stall_cycles);
        if (error_count == 0 && verdict_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/urlv_pkg.sv
sv/urlv_class.sv
sv/urlv_fsm.sv
sv/http_request_url_validator.sv
bench/tb_top.sv
